### sv/nnrp_pkg.sv
package nnrp_pkg;

    localparam int NAME_BUFFER_BYTES = 64;
    localparam int CNT_W = $clog2(NAME_BUFFER_BYTES);

    localparam logic [1:0] PH_NAME   = 2'd0;
    localparam logic [1:0] PH_NUMBER = 2'd1;
    localparam logic [1:0] PH_DRAIN  = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_COMMA  = 3'd1;
    localparam logic [2:0] ST_TOO_LONG  = 3'd2;
    localparam logic [2:0] ST_OVERFLOW  = 3'd3;
    localparam logic [2:0] ST_BAD_CHAR  = 3'd4;
    localparam logic [2:0] ST_NO_DIGITS = 3'd5;

    localparam logic [7:0] CH_NUL   = 8'd0;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic KIND_NAME    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

endpackage

### sv/name_number_record_parser.sv
// Parses records of the form name ',' blanks digits, terminated by LF or NUL, one byte
// per cycle. Each name byte is forwarded as a name transfer; the terminator produces
// one summary transfer with the 64-bit value, name length and status. After an error
// the rest of the record is dropped and the error is reported at the terminator.
// Throughput is one byte per cycle: the record state and the times-ten accumulate
// are updated in the cycle a byte is taken, and results go to a single output
// register. in_ready is low only while that register holds a result not yet taken.
module name_number_record_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  name_char,
    output logic [5:0]  name_index,
    output logic [63:0] value,
    output logic [5:0]  name_length,
    output logic [2:0]  status
);

    logic [1:0]                 phase_reg, phase_next;
    logic [nnrp_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                       digit_seen_reg, digit_seen_next;
    logic [63:0]                acc_reg, acc_next;
    logic [2:0]                 err_reg, err_next;

    logic        out_valid_reg, out_valid_next;
    logic        kind_reg;
    logic [7:0]  name_char_reg;
    logic [5:0]  name_index_reg;
    logic [63:0] value_reg;
    logic [5:0]  name_length_reg;
    logic [2:0]  status_reg;

    logic        accept;
    logic        term;
    logic        is_digit;
    logic        is_blank;
    logic [67:0] times_ten;
    logic        emit;
    logic        emit_kind;
    logic [2:0]  emit_status;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign term     = (in_byte == nnrp_pkg::CH_LF) || (in_byte == nnrp_pkg::CH_NUL);
    assign is_digit = (in_byte >= nnrp_pkg::CH_ZERO) && (in_byte <= nnrp_pkg::CH_NINE);
    assign is_blank = (in_byte == nnrp_pkg::CH_TAB) || (in_byte == nnrp_pkg::CH_SPACE);

    // v*10 + d with headroom; any carry into the top nibble is an overflow
    assign times_ten = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                     + {60'b0, in_byte - nnrp_pkg::CH_ZERO};

    always_comb
    begin
        phase_next      = phase_reg;
        cnt_next        = cnt_reg;
        digit_seen_next = digit_seen_reg;
        acc_next        = acc_reg;
        err_next        = err_reg;
        emit            = 1'b0;
        emit_kind       = nnrp_pkg::KIND_NAME;
        emit_status     = nnrp_pkg::ST_OK;

        unique case (phase_reg)
            nnrp_pkg::PH_NAME:
            begin
                if (in_byte == nnrp_pkg::CH_COMMA)
                begin
                    phase_next = nnrp_pkg::PH_NUMBER;
                end
                else if (term)
                begin
                    emit        = 1'b1;
                    emit_kind   = nnrp_pkg::KIND_SUMMARY;
                    emit_status = nnrp_pkg::ST_NO_COMMA;
                end
                else if (cnt_reg >= nnrp_pkg::CNT_W'(nnrp_pkg::NAME_BUFFER_BYTES - 1))
                begin
                    err_next   = nnrp_pkg::ST_TOO_LONG;
                    phase_next = nnrp_pkg::PH_DRAIN;
                end
                else
                begin
                    emit     = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            nnrp_pkg::PH_NUMBER:
            begin
                if (term)
                begin
                    emit        = 1'b1;
                    emit_kind   = nnrp_pkg::KIND_SUMMARY;
                    emit_status = digit_seen_reg ? nnrp_pkg::ST_OK : nnrp_pkg::ST_NO_DIGITS;
                end
                else if (!digit_seen_reg && is_blank)
                begin
                    phase_next = nnrp_pkg::PH_NUMBER;
                end
                else if (is_digit)
                begin
                    if (times_ten[67:64] != 4'd0)
                    begin
                        err_next   = nnrp_pkg::ST_OVERFLOW;
                        phase_next = nnrp_pkg::PH_DRAIN;
                    end
                    else
                    begin
                        acc_next        = times_ten[63:0];
                        digit_seen_next = 1'b1;
                    end
                end
                else
                begin
                    err_next   = nnrp_pkg::ST_BAD_CHAR;
                    phase_next = nnrp_pkg::PH_DRAIN;
                end
            end
            default:
            begin
                if (term)
                begin
                    emit        = 1'b1;
                    emit_kind   = nnrp_pkg::KIND_SUMMARY;
                    emit_status = err_reg;
                end
            end
        endcase

        // summary starts a fresh record
        if (emit && (emit_kind == nnrp_pkg::KIND_SUMMARY))
        begin
            phase_next      = nnrp_pkg::PH_NAME;
            cnt_next        = '0;
            digit_seen_next = 1'b0;
            acc_next        = 64'd0;
            err_next        = nnrp_pkg::ST_OK;
        end
    end

    always_comb
    begin
        if (accept && emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= nnrp_pkg::PH_NAME;
            cnt_reg        <= '0;
            digit_seen_reg <= 1'b0;
            acc_reg        <= 64'd0;
            err_reg        <= nnrp_pkg::ST_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg      <= phase_next;
                cnt_reg        <= cnt_next;
                digit_seen_reg <= digit_seen_next;
                acc_reg        <= acc_next;
                err_reg        <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            kind_reg <= emit_kind;
            if (emit_kind == nnrp_pkg::KIND_SUMMARY)
            begin
                name_char_reg   <= 8'd0;
                name_index_reg  <= 6'd0;
                value_reg       <= (emit_status == nnrp_pkg::ST_OK) ? acc_reg : 64'd0;
                name_length_reg <= 6'(cnt_reg);
                status_reg      <= emit_status;
            end
            else
            begin
                name_char_reg   <= in_byte;
                name_index_reg  <= 6'(cnt_reg);
                value_reg       <= 64'd0;
                name_length_reg <= 6'd0;
                status_reg      <= nnrp_pkg::ST_OK;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign name_char   = name_char_reg;
    assign name_index  = name_index_reg;
    assign value       = value_reg;
    assign name_length = name_length_reg;
    assign status      = status_reg;

endmodule

### tb/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] U64_MAX = '1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  ch;
        logic [5:0]  idx;
        logic [63:0] val;
        logic [5:0]  len;
        logic [2:0]  st;
    } parser_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  in_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        kind;
    logic [7:0]  name_char;
    logic [5:0]  name_index;
    logic [63:0] value;
    logic [5:0]  name_length;
    logic [2:0]  status;

    name_number_record_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .name_char   (name_char),
        .name_index  (name_index),
        .value       (value),
        .name_length (name_length),
        .status      (status)
    );

    always #5ns clk = ~clk;

    logic [7:0]  byte_stream[$];
    parser_out_t awaited_outputs[$];
    int          error_count = 0;

    // record state of the parser as predicted
    logic [1:0]  rec_phase = nnrp_pkg::PH_NAME;
    int          rec_name_len = 0;
    logic        rec_digit_seen = 1'b0;
    logic [63:0] rec_value = '0;
    logic [2:0]  rec_error = nnrp_pkg::ST_OK;

    int          in_gap = 0;
    bit          in_burst = 1'b0;
    int          out_stall = 0;
    bit          out_burst = 1'b0;

    task automatic report(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic close_record(input logic [2:0] st);
        parser_out_t r;
        r = '0;
        r.kind = nnrp_pkg::KIND_SUMMARY;
        r.val = (st == nnrp_pkg::ST_OK) ? rec_value : 64'd0;
        r.len = rec_name_len[5:0];
        r.st = st;
        awaited_outputs.push_back(r);
        rec_phase = nnrp_pkg::PH_NAME;
        rec_name_len = 0;
        rec_digit_seen = 1'b0;
        rec_value = '0;
        rec_error = nnrp_pkg::ST_OK;
    endtask

    task automatic parse_byte(input logic [7:0] b);
        logic        term;
        logic        is_digit;
        logic [63:0] d;
        parser_out_t r;
        term = (b == nnrp_pkg::CH_LF) || (b == nnrp_pkg::CH_NUL);
        is_digit = (b >= nnrp_pkg::CH_ZERO) && (b <= nnrp_pkg::CH_NINE);
        d = 64'(b) - 64'(nnrp_pkg::CH_ZERO);
        r = '0;
        case (rec_phase)
            nnrp_pkg::PH_NAME:
            begin
                if (b == nnrp_pkg::CH_COMMA)
                    rec_phase = nnrp_pkg::PH_NUMBER;
                else if (term)
                    close_record(nnrp_pkg::ST_NO_COMMA);
                else if (rec_name_len >= nnrp_pkg::NAME_BUFFER_BYTES - 1)
                begin
                    rec_error = nnrp_pkg::ST_TOO_LONG;
                    rec_phase = nnrp_pkg::PH_DRAIN;
                end
                else
                begin
                    r.kind = nnrp_pkg::KIND_NAME;
                    r.ch = b;
                    r.idx = rec_name_len[5:0];
                    awaited_outputs.push_back(r);
                    rec_name_len++;
                end
            end
            nnrp_pkg::PH_NUMBER:
            begin
                if (term)
                    close_record(rec_digit_seen ? nnrp_pkg::ST_OK : nnrp_pkg::ST_NO_DIGITS);
                else if (!rec_digit_seen
                         && (b == nnrp_pkg::CH_TAB || b == nnrp_pkg::CH_SPACE))
                    ;
                else if (is_digit)
                begin
                    if (rec_value > U64_MAX / 64'd10 || rec_value * 64'd10 > U64_MAX - d)
                    begin
                        rec_error = nnrp_pkg::ST_OVERFLOW;
                        rec_phase = nnrp_pkg::PH_DRAIN;
                    end
                    else
                    begin
                        rec_value = rec_value * 64'd10 + d;
                        rec_digit_seen = 1'b1;
                    end
                end
                else
                begin
                    rec_error = nnrp_pkg::ST_BAD_CHAR;
                    rec_phase = nnrp_pkg::PH_DRAIN;
                end
            end
            default:
            begin
                if (term)
                    close_record(rec_error);
            end
        endcase
    endtask

    task automatic check_output();
        parser_out_t want;
        if (awaited_outputs.size() == 0)
        begin
            report($sformatf("unexpected result kind=%0d status=%0d", kind, status));
            return;
        end
        want = awaited_outputs.pop_front();
        if (kind !== want.kind)
            report($sformatf("kind got %0d want %0d", kind, want.kind));
        if (name_char !== want.ch)
            report($sformatf("name_char got %0h want %0h", name_char, want.ch));
        if (name_index !== want.idx)
            report($sformatf("name_index got %0d want %0d", name_index, want.idx));
        if (value !== want.val)
            report($sformatf("value got %0d want %0d", value, want.val));
        if (name_length !== want.len)
            report($sformatf("name_length got %0d want %0d", name_length, want.len));
        if (status !== want.st)
            report($sformatf("status got %0d want %0d", status, want.st));
    endtask

    // driver: one byte per transfer, random idle gap before each
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                parse_byte(in_byte);
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0 || byte_stream.size() == 0)
                begin
                    if (in_gap > 0)
                        in_gap--;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_byte <= byte_stream.pop_front();
                    if ($urandom_range(0, 49) == 0)
                        in_burst = !in_burst;
                    in_gap = in_burst ? 0 : $urandom_range(0, 4);
                end
            end
        end
    end

    // monitor: stall count is drawn per result and burned while a result waits
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                check_output();
                if ($urandom_range(0, 49) == 0)
                    out_burst = !out_burst;
                out_stall = out_burst ? 0 : $urandom_range(0, 4);
            end
            else if (out_valid && out_stall > 0)
                out_stall--;
            out_ready <= (out_stall == 0);
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_stream.push_back(b);
    endtask

    task automatic push_text(input string s);
        foreach (s[i])
            byte_stream.push_back(s[i]);
    endtask

    function automatic logic [7:0] term_byte();
        return $urandom_range(0, 1) ? nnrp_pkg::CH_LF : nnrp_pkg::CH_NUL;
    endfunction

    function automatic logic [7:0] name_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == nnrp_pkg::CH_LF || b == nnrp_pkg::CH_COMMA);
        return b;
    endfunction

    task automatic gen_record();
        int         pick;
        int         n;
        logic [7:0] b;
        string      near_max;
        near_max = "1844674407370955161";
        pick = $urandom_range(0, 99);
        if (pick < 6)
        begin
            // raw noise, any byte value
            repeat ($urandom_range(1, 8))
                push_byte(8'($urandom_range(0, 255)));
            push_byte(term_byte());
            return;
        end
        if (pick < 12)
        begin
            // name at the buffer limit: then comma, terminator, or more name
            repeat (nnrp_pkg::NAME_BUFFER_BYTES - 1)
                push_byte(name_byte());
            n = $urandom_range(0, 2);
            if (n == 1)
            begin
                push_byte(term_byte());
                return;
            end
            if (n == 2)
                repeat ($urandom_range(1, 3))
                    push_byte(name_byte());
        end
        else
        begin
            repeat ($urandom_range(0, 8))
                push_byte(name_byte());
            if ($urandom_range(0, 7) == 0)
            begin
                push_byte(term_byte());
                return;
            end
        end
        push_byte(nnrp_pkg::CH_COMMA);
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3))
                push_byte($urandom_range(0, 1) ? nnrp_pkg::CH_TAB : nnrp_pkg::CH_SPACE);
        pick = $urandom_range(0, 9);
        if (pick == 1)
        begin
            push_text(near_max);
            push_byte(nnrp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (pick == 2)
        begin
            push_byte(nnrp_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
            repeat ($urandom_range(18, 20))
                push_byte(nnrp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        else if (pick != 0)
            repeat ($urandom_range(1, 6))
                push_byte(nnrp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 7) == 0)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == nnrp_pkg::CH_LF || b == nnrp_pkg::CH_NUL
                   || (b >= nnrp_pkg::CH_ZERO && b <= nnrp_pkg::CH_NINE));
            push_byte(b);
            repeat ($urandom_range(0, 2))
                push_byte(nnrp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        push_byte(term_byte());
    endtask

    initial
    begin
        int waited;

        push_text("a,0\n");
        push_text("\n");
        push_byte(8'hff);
        push_byte(8'h01);
        push_byte(nnrp_pkg::CH_NUL);
        push_text(",18446744073709551615\n");
        push_text(",18446744073709551616\n");
        push_text("b, \t7");
        push_byte(nnrp_pkg::CH_NUL);
        push_text("c,1 \n");
        push_text("d,x\n");
        push_text(", \t\n");
        while (byte_stream.size() < 1350)
            gen_record();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // sample at the falling edge so driver updates have settled
        do
            @(negedge clk);
        while (byte_stream.size() != 0 || in_valid);
        waited = 0;
        while (awaited_outputs.size() != 0 && waited < 2000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        if (awaited_outputs.size() != 0)
            report($sformatf("%0d expected results never arrived", awaited_outputs.size()));
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

endmodule
